>>> src/swpr_pkg.sv
// ----------------------------------------------------------------------------
// swpr_pkg
// Shared types and constants for the single-wire pad responder.
// ----------------------------------------------------------------------------
package swpr_pkg;

  localparam int unsigned COMMAND_BITS   = 8;
  localparam int unsigned RESPONSE_BYTES = 4;

  localparam int unsigned TICK_W  = 8;
  localparam int unsigned BIT_W   = 6;
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WAIT_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WAIT_LIMIT = 2'd3;

  localparam logic [CFG_W-1:0] RST_TICKS_PER_US    = 8'd16;
  localparam logic [CFG_W-1:0] RST_SAMPLE_DELAY    = 8'h20;
  localparam logic [CFG_W-1:0] RST_LOW_WAIT_LIMIT  = 8'h30;
  localparam logic [CFG_W-1:0] RST_HIGH_WAIT_LIMIT = 8'h3f;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SAMPLE    = 3'd1,
    PH_WAIT_HIGH = 3'd2,
    PH_WAIT_LOW  = 3'd3,
    PH_REPLY     = 3'd4,
    PH_STOP      = 3'd5
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] ticks_per_us;
    logic [CFG_W-1:0] sample_delay;
    logic [CFG_W-1:0] low_wait_limit;
    logic [CFG_W-1:0] high_wait_limit;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] response_word;
    logic              line_in;
  } item_t;

  typedef struct packed {
    logic             reply_done;
    logic             timeout_flag;
    logic [CMD_W-1:0] cmd_bits;
    logic             cmd_valid;
    logic             busy_res;
    logic             drive_low;
  } res_t;

endpackage

>>> src/single_wire_pad_responder_unit.sv
// ----------------------------------------------------------------------------
// single_wire_pad_responder_unit
// Device side of a pulse-width coded single-wire link, one line tick per beat.
// ----------------------------------------------------------------------------
//  channel | dir | signals                          | beat
//  in      | in  | in_tvalid/in_tready/in_tdata     | one sampled line tick
//  out     | out | out_tvalid/out_tready/out_tdata  | one result per tick
//  cfg     | in  | cfg_we/cfg_index/cfg_wdata       | one register write
//
//  One beat per cycle sustained while out takes every result; each beat passes
//  the input register, a state machine step and the result register.
//  Reset (rst_n low, synchronous) empties both registers, loads the default
//  timing registers and returns the state machine to idle; no clearing pass.
//  A stall on out holds the result and backs up into in_tready.
// ----------------------------------------------------------------------------
module single_wire_pad_responder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] line_in, [32:1] response_word, [39:33] zero
  input  logic [swpr_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] drive_low, [1] busy_res, [2] cmd_valid, [10:3] cmd_bits,
  // [11] timeout_flag, [12] reply_done, [15:13] zero
  output logic [swpr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [swpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swpr_pkg::CFG_W-1:0]       cfg_wdata
);

  swpr_pkg::cfg_t  cfg;
  swpr_pkg::item_t item;
  swpr_pkg::res_t  res;
  logic            item_valid;
  logic            space;
  logic            take;

  assign take = item_valid && space;

  swpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  swpr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  swpr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (take),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  swpr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.cmd_valid |-> res.busy_res && !res.timeout_flag)
    else $error("command complete without entering reply");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take && (res.timeout_flag || res.reply_done) |-> !res.busy_res)
    else $error("abort or stop end left the block busy");

  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.drive_low && !res.reply_done |-> res.busy_res)
    else $error("line driven outside a reply");

  a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && !space |=> item_valid && $stable(item))
    else $error("input register lost a stalled beat");

endmodule

>>> src/swpr_cfg_regs.sv
// ----------------------------------------------------------------------------
// swpr_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module swpr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [swpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swpr_pkg::CFG_W-1:0]     cfg_wdata,
  output swpr_pkg::cfg_t                 cfg
);

  swpr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_us    <= swpr_pkg::RST_TICKS_PER_US;
      cfg_r.sample_delay    <= swpr_pkg::RST_SAMPLE_DELAY;
      cfg_r.low_wait_limit  <= swpr_pkg::RST_LOW_WAIT_LIMIT;
      cfg_r.high_wait_limit <= swpr_pkg::RST_HIGH_WAIT_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swpr_pkg::CFG_TICKS_PER_US:    cfg_r.ticks_per_us    <= cfg_wdata;
        swpr_pkg::CFG_SAMPLE_DELAY:    cfg_r.sample_delay    <= cfg_wdata;
        swpr_pkg::CFG_LOW_WAIT_LIMIT:  cfg_r.low_wait_limit  <= cfg_wdata;
        swpr_pkg::CFG_HIGH_WAIT_LIMIT: cfg_r.high_wait_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/swpr_in_stage.sv
// ----------------------------------------------------------------------------
// swpr_in_stage
// Input register: holds one sampled tick until the core consumes it.
// ----------------------------------------------------------------------------
module swpr_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [swpr_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                            take,
  output logic                            item_valid,
  output swpr_pkg::item_t                 item
);

  logic            valid_r;
  logic            valid_nxt;
  swpr_pkg::item_t item_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.line_in       <= in_tdata[0];
      item_r.response_word <= in_tdata[swpr_pkg::WORD_W:1];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> src/swpr_core.sv
// ----------------------------------------------------------------------------
// swpr_core
// Receive/reply state machine; advances one line tick per step.
// ----------------------------------------------------------------------------
module swpr_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  swpr_pkg::item_t item,
  input  swpr_pkg::cfg_t  cfg,
  output swpr_pkg::res_t  res
);

  localparam int unsigned TW = swpr_pkg::TICK_W;
  localparam int unsigned BW = swpr_pkg::BIT_W;
  localparam int unsigned WW = swpr_pkg::WORD_W;
  localparam int unsigned CW = swpr_pkg::CMD_W;
  localparam logic [BW-1:0] CMD_END   = BW'(swpr_pkg::COMMAND_BITS);
  localparam logic [BW-1:0] REPLY_END = BW'(swpr_pkg::RESPONSE_BYTES * 8);

  swpr_pkg::phase_t phase_r, phase_nxt;
  logic [TW-1:0] tick_count_r, tick_count_nxt;
  logic [BW-1:0] bit_count_r, bit_count_nxt;
  logic [WW-1:0] reply_shift_r, reply_shift_nxt;
  logic [CW-1:0] cmd_shift_r, cmd_shift_nxt;
  logic [1:0]    us_count_r, us_count_nxt;

  logic [TW-1:0] tc_inc;
  logic [BW-1:0] bc_inc;
  logic [TW-1:0] us_ticks;
  logic          sample_hit, us_hit, high_tmo, low_tmo, cmd_done, reply_end, us_wrap;
  logic          line;
  logic          drive, valid, tmo, done;

  assign line       = item.line_in;
  assign tc_inc     = tick_count_r + TW'(1);
  assign bc_inc     = bit_count_r + BW'(1);
  assign us_ticks   = (cfg.ticks_per_us == '0) ? TW'(1) : cfg.ticks_per_us;
  assign sample_hit = (tc_inc >= cfg.sample_delay) || (tc_inc == '0);
  assign us_hit     = tc_inc >= us_ticks;
  assign high_tmo   = tc_inc >= cfg.high_wait_limit;
  assign low_tmo    = tc_inc >= cfg.low_wait_limit;
  assign cmd_done   = bc_inc >= CMD_END;
  assign reply_end  = bc_inc >= REPLY_END;
  assign us_wrap    = us_count_r == 2'd3;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      swpr_pkg::PH_SAMPLE: begin
        if (sample_hit) begin
          phase_nxt = cmd_done ? swpr_pkg::PH_REPLY : swpr_pkg::PH_WAIT_HIGH;
        end
      end
      swpr_pkg::PH_WAIT_HIGH: begin
        if (line) begin
          phase_nxt = swpr_pkg::PH_WAIT_LOW;
        end else if (high_tmo) begin
          phase_nxt = swpr_pkg::PH_IDLE;
        end
      end
      swpr_pkg::PH_WAIT_LOW: begin
        if (!line) begin
          phase_nxt = swpr_pkg::PH_SAMPLE;
        end else if (low_tmo) begin
          phase_nxt = swpr_pkg::PH_IDLE;
        end
      end
      swpr_pkg::PH_REPLY: begin
        if (us_hit && us_wrap && reply_end) begin
          phase_nxt = swpr_pkg::PH_STOP;
        end
      end
      swpr_pkg::PH_STOP: begin
        if (us_hit) begin
          phase_nxt = swpr_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = line ? swpr_pkg::PH_IDLE : swpr_pkg::PH_SAMPLE;
      end
    endcase
  end

  // counters, shifters and per-tick flags
  always_comb begin
    tick_count_nxt  = tick_count_r;
    bit_count_nxt   = bit_count_r;
    reply_shift_nxt = reply_shift_r;
    cmd_shift_nxt   = cmd_shift_r;
    us_count_nxt    = us_count_r;
    drive = 1'b0;
    valid = 1'b0;
    tmo   = 1'b0;
    done  = 1'b0;
    unique case (phase_r)
      swpr_pkg::PH_SAMPLE: begin
        tick_count_nxt = tc_inc;
        if (sample_hit) begin
          cmd_shift_nxt  = {cmd_shift_r[CW-2:0], line};
          bit_count_nxt  = bc_inc;
          tick_count_nxt = '0;
          if (cmd_done) begin
            valid           = 1'b1;
            reply_shift_nxt = item.response_word;
            bit_count_nxt   = '0;
            us_count_nxt    = '0;
          end
        end
      end
      swpr_pkg::PH_WAIT_HIGH: begin
        if (line) begin
          tick_count_nxt = '0;
        end else begin
          tick_count_nxt = tc_inc;
          if (high_tmo) begin
            tmo            = 1'b1;
            tick_count_nxt = '0;
          end
        end
      end
      swpr_pkg::PH_WAIT_LOW: begin
        if (!line) begin
          tick_count_nxt = '0;
        end else begin
          tick_count_nxt = tc_inc;
          if (low_tmo) begin
            tmo            = 1'b1;
            tick_count_nxt = '0;
          end
        end
      end
      swpr_pkg::PH_REPLY: begin
        drive = (us_count_r == 2'd0) || (us_count_r != 2'd3 && !reply_shift_r[WW-1]);
        tick_count_nxt = tc_inc;
        if (us_hit) begin
          tick_count_nxt = '0;
          us_count_nxt   = us_count_r + 2'd1;
          if (us_wrap) begin
            reply_shift_nxt = {reply_shift_r[WW-2:0], 1'b0};
            bit_count_nxt   = bc_inc;
          end
        end
      end
      swpr_pkg::PH_STOP: begin
        drive          = 1'b1;
        tick_count_nxt = tc_inc;
        if (us_hit) begin
          done           = 1'b1;
          tick_count_nxt = '0;
          bit_count_nxt  = '0;
        end
      end
      default: begin
        if (!line) begin
          tick_count_nxt = '0;
          bit_count_nxt  = '0;
          cmd_shift_nxt  = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= swpr_pkg::PH_IDLE;
      tick_count_r  <= '0;
      bit_count_r   <= '0;
      reply_shift_r <= '0;
      cmd_shift_r   <= '0;
      us_count_r    <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      bit_count_r   <= bit_count_nxt;
      reply_shift_r <= reply_shift_nxt;
      cmd_shift_r   <= cmd_shift_nxt;
      us_count_r    <= us_count_nxt;
    end
  end

  assign res.drive_low    = drive;
  assign res.busy_res     = phase_nxt != swpr_pkg::PH_IDLE;
  assign res.cmd_valid    = valid;
  assign res.cmd_bits     = cmd_shift_nxt;
  assign res.timeout_flag = tmo;
  assign res.reply_done   = done;

endmodule

>>> src/swpr_out_stage.sv
// ----------------------------------------------------------------------------
// swpr_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module swpr_out_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  swpr_pkg::res_t                   res,
  output logic                             space,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [swpr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned RES_W = $bits(swpr_pkg::res_t);

  logic           valid_r;
  logic           valid_nxt;
  swpr_pkg::res_t res_r;

  assign space     = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(swpr_pkg::OUT_TDATA_W - RES_W){1'b0}}, res_r};

endmodule

>>> sim/single_wire_pad_responder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_pad_responder_unit_tb
// Self-checking bench for the single-wire pad responder. Each beat is one line
// tick; a cycle-accurate predictor of the receive/reply state machine computes
// the result of every accepted tick. A short table of ticks at zero timing
// registers opens the run. Four traffic phases follow, each with its own
// timing and some with their own idling mix: well-formed commands with random
// bits, commands that time out in either wait, and line noise. The last phase
// holds off the result side long enough to back up the input.
// ----------------------------------------------------------------------------
module single_wire_pad_responder_unit_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int CFG_BITS    = swpr_pkg::CFG_W;
  localparam int TICK_BITS   = swpr_pkg::TICK_W;

  typedef struct {
    logic                        line;
    logic [swpr_pkg::WORD_W-1:0] word;
    bit                          typed;
    swpr_pkg::res_t              exp;
  } dir_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [swpr_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [swpr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_we;
  logic [swpr_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [swpr_pkg::CFG_W-1:0]       cfg_wdata;

  // predictor state
  swpr_pkg::cfg_t              pad_cfg;
  swpr_pkg::phase_t            pad_phase;
  logic [swpr_pkg::TICK_W-1:0] pad_tick;
  logic [swpr_pkg::BIT_W-1:0]  pad_bits;
  logic [swpr_pkg::WORD_W-1:0] pad_reply;
  logic [swpr_pkg::CMD_W-1:0]  pad_cmd;
  logic [1:0]                  pad_us;

  swpr_pkg::res_t tick_results_due[$];
  dir_row_t       dir_rows[10];
  int             errors       = 0;
  int             active_ticks = 0;
  int             stall_cycles = 0;
  int             tx_idle_pct  = 0;
  int             rx_idle_pct  = 0;
  int             hold_left    = 0;
  bit             hold_go      = 1'b0;

  single_wire_pad_responder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic swpr_pkg::res_t mk_res(logic drive, logic busy, logic valid,
                                            logic [swpr_pkg::CMD_W-1:0] cmd,
                                            logic tmo, logic done);
    swpr_pkg::res_t r;
    r.drive_low    = drive;
    r.busy_res     = busy;
    r.cmd_valid    = valid;
    r.cmd_bits     = cmd;
    r.timeout_flag = tmo;
    r.reply_done   = done;
    return r;
  endfunction

  function automatic int at_least_one(int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic logic rand_line();
    int unsigned r;
    r = $urandom_range(1);
    return r[0];
  endfunction

  function automatic logic [swpr_pkg::CFG_W-1:0] rand_cfg(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(hi, lo);
    return r[swpr_pkg::CFG_W-1:0];
  endfunction

  // ticks spent in a wait without tripping its limit, mostly short
  function automatic int wait_len(int limit);
    int hi;
    if (limit <= 1) return 0;
    hi = limit - 1;
    if (hi > 6 && $urandom_range(7) != 0) hi = 6;
    return $urandom_range(hi);
  endfunction

  function automatic logic [swpr_pkg::WORD_W-1:0] pick_word();
    unique case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // one line tick of the responder
  function automatic swpr_pkg::res_t responder_step(swpr_pkg::item_t it);
    swpr_pkg::res_t              r;
    logic                        rbit;
    logic [swpr_pkg::TICK_W-1:0] us;
    r  = '0;
    us = (pad_cfg.ticks_per_us == '0) ? TICK_BITS'(1) : pad_cfg.ticks_per_us;
    unique case (pad_phase)
      swpr_pkg::PH_SAMPLE: begin
        pad_tick = pad_tick + 1'b1;
        if (pad_tick >= pad_cfg.sample_delay || pad_tick == 0) begin
          pad_cmd  = {pad_cmd[swpr_pkg::CMD_W-2:0], it.line_in};
          pad_bits = pad_bits + 1'b1;
          pad_tick = '0;
          if (pad_bits >= swpr_pkg::COMMAND_BITS) begin
            r.cmd_valid = 1'b1;
            pad_reply   = it.response_word;
            pad_bits    = '0;
            pad_us      = '0;
            pad_phase   = swpr_pkg::PH_REPLY;
          end else begin
            pad_phase = swpr_pkg::PH_WAIT_HIGH;
          end
        end
      end
      swpr_pkg::PH_WAIT_HIGH: begin
        if (it.line_in) begin
          pad_tick  = '0;
          pad_phase = swpr_pkg::PH_WAIT_LOW;
        end else begin
          pad_tick = pad_tick + 1'b1;
          if (pad_tick >= pad_cfg.high_wait_limit) begin
            r.timeout_flag = 1'b1;
            pad_tick       = '0;
            pad_phase      = swpr_pkg::PH_IDLE;
          end
        end
      end
      swpr_pkg::PH_WAIT_LOW: begin
        if (!it.line_in) begin
          pad_tick  = '0;
          pad_phase = swpr_pkg::PH_SAMPLE;
        end else begin
          pad_tick = pad_tick + 1'b1;
          if (pad_tick >= pad_cfg.low_wait_limit) begin
            r.timeout_flag = 1'b1;
            pad_tick       = '0;
            pad_phase      = swpr_pkg::PH_IDLE;
          end
        end
      end
      swpr_pkg::PH_REPLY: begin
        rbit        = pad_reply[swpr_pkg::WORD_W-1];
        r.drive_low = (pad_us == 0) || (pad_us < 3 && !rbit);
        pad_tick    = pad_tick + 1'b1;
        if (pad_tick >= us) begin
          pad_tick = '0;
          pad_us   = pad_us + 1'b1;
          if (pad_us == 0) begin
            pad_reply = pad_reply << 1;
            pad_bits  = pad_bits + 1'b1;
            if (pad_bits >= swpr_pkg::RESPONSE_BYTES * 8) pad_phase = swpr_pkg::PH_STOP;
          end
        end
      end
      swpr_pkg::PH_STOP: begin
        r.drive_low = 1'b1;
        pad_tick    = pad_tick + 1'b1;
        if (pad_tick >= us) begin
          r.reply_done = 1'b1;
          pad_tick     = '0;
          pad_bits     = '0;
          pad_phase    = swpr_pkg::PH_IDLE;
        end
      end
      default: begin
        if (!it.line_in) begin
          pad_phase = swpr_pkg::PH_SAMPLE;
          pad_tick  = '0;
          pad_bits  = '0;
          pad_cmd   = '0;
        end else begin
          pad_phase = swpr_pkg::PH_IDLE;
        end
      end
    endcase
    r.busy_res = (pad_phase != swpr_pkg::PH_IDLE);
    r.cmd_bits = pad_cmd;
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(input swpr_pkg::item_t it, input bit typed,
                           input swpr_pkg::res_t exp);
    swpr_pkg::res_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= swpr_pkg::IN_TDATA_W'(it);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = responder_step(it);
    tick_results_due.push_back(typed ? exp : pred);
    @(negedge clk);
  endtask

  task automatic line_tick(input logic line, input bit counted);
    swpr_pkg::item_t it;
    it.line_in       = line;
    it.response_word = pick_word();
    send_beat(it, 1'b0, '0);
    if (counted) active_ticks++;
  endtask

  // one command; a broken one stops with a timeout in one of the waits
  task automatic send_frame(input bit broken);
    int cut;
    int eff_sd;
    cut    = broken ? $urandom_range(swpr_pkg::COMMAND_BITS - 2) : swpr_pkg::COMMAND_BITS;
    eff_sd = at_least_one(pad_cfg.sample_delay);
    for (int b = 0; b < swpr_pkg::COMMAND_BITS; b++) begin
      line_tick(1'b0, 1'b1);
      repeat (eff_sd - 1) line_tick(rand_line(), 1'b1);
      line_tick(rand_line(), 1'b1);
      if (b == swpr_pkg::COMMAND_BITS - 1) break;
      if (b == cut) begin
        if ($urandom_range(1)) begin
          repeat (at_least_one(pad_cfg.high_wait_limit)) line_tick(1'b0, 1'b1);
        end else begin
          line_tick(1'b1, 1'b1);
          repeat (at_least_one(pad_cfg.low_wait_limit)) line_tick(1'b1, 1'b1);
        end
        return;
      end
      repeat (wait_len(pad_cfg.high_wait_limit)) line_tick(1'b0, 1'b1);
      line_tick(1'b1, 1'b1);
      repeat (wait_len(pad_cfg.low_wait_limit)) line_tick(1'b1, 1'b1);
    end
    // line activity during the reply is ignored by the block
    repeat ((swpr_pkg::RESPONSE_BYTES * 32 + 1) * at_least_one(pad_cfg.ticks_per_us))
      line_tick(rand_line(), 1'b1);
  endtask

  task automatic run_traffic(input int target);
    int stop_at;
    int kind;
    stop_at = active_ticks + target;
    while (active_ticks < stop_at) begin
      kind = $urandom_range(9);
      if (kind < 7) send_frame(1'b0);
      else if (kind < 9) send_frame(1'b1);
      else repeat ($urandom_range(1, 12)) line_tick(rand_line(), 1'b1);
      repeat ($urandom_range(1, 4)) line_tick(1'b1, 1'b0);
    end
  endtask

  task automatic set_timing(input logic [swpr_pkg::CFG_W-1:0] tpu,
                            input logic [swpr_pkg::CFG_W-1:0] sd,
                            input logic [swpr_pkg::CFG_W-1:0] lwl,
                            input logic [swpr_pkg::CFG_W-1:0] hwl);
    logic [swpr_pkg::CFG_IDX_W-1:0] idx[4];
    logic [swpr_pkg::CFG_W-1:0]     val[4];
    idx = '{swpr_pkg::CFG_TICKS_PER_US, swpr_pkg::CFG_SAMPLE_DELAY,
            swpr_pkg::CFG_LOW_WAIT_LIMIT, swpr_pkg::CFG_HIGH_WAIT_LIMIT};
    val = '{tpu, sd, lwl, hwl};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    pad_cfg.ticks_per_us    = tpu;
    pad_cfg.sample_delay    = sd;
    pad_cfg.low_wait_limit  = lwl;
    pad_cfg.high_wait_limit = hwl;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (tick_results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cmp_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
      errors++;
    end
  endtask

  task automatic check_result(input swpr_pkg::res_t got);
    swpr_pkg::res_t exp;
    if (tick_results_due.size() == 0) begin
      $error("result beat with nothing expected: 0x%0h", got);
      errors++;
      return;
    end
    exp = tick_results_due.pop_front();
    cmp_field("drive_low", exp.drive_low, got.drive_low);
    cmp_field("busy_res", exp.busy_res, got.busy_res);
    cmp_field("cmd_valid", exp.cmd_valid, got.cmd_valid);
    cmp_field("cmd_bits", exp.cmd_bits, got.cmd_bits);
    cmp_field("timeout_flag", exp.timeout_flag, got.timeout_flag);
    cmp_field("reply_done", exp.reply_done, got.reply_done);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_result(swpr_pkg::res_t'(out_tdata[$bits(swpr_pkg::res_t)-1:0]));
  end

  // result side: random stalls plus one long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("single_wire_pad_responder_unit verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    swpr_pkg::item_t it;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    // all timing registers zero: sample on the first tick, waits trip at once
    dir_rows = '{
      '{1'b1, 32'h0000_0000, 1'b1, mk_res(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0)},
      '{1'b1, 32'hffff_ffff, 1'b1, mk_res(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0)},
      '{1'b0, 32'hffff_ffff, 1'b1, mk_res(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)},
      '{1'b1, 32'h0000_0000, 1'b1, mk_res(1'b0, 1'b1, 1'b0, 8'h01, 1'b0, 1'b0)},
      '{1'b0, 32'h8000_0001, 1'b1, mk_res(1'b0, 1'b0, 1'b0, 8'h01, 1'b1, 1'b0)},
      '{1'b0, 32'h7fff_fffe, 1'b1, mk_res(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)},
      '{1'b0, 32'h0000_0000, 1'b1, mk_res(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)},
      '{1'b1, 32'hffff_ffff, 1'b0, '0},
      '{1'b1, 32'h0000_0000, 1'b1, mk_res(1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0)},
      '{1'b1, 32'h5a5a_5a5a, 1'b1, mk_res(1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0)}
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    pad_cfg   = '{swpr_pkg::RST_TICKS_PER_US, swpr_pkg::RST_SAMPLE_DELAY,
                  swpr_pkg::RST_LOW_WAIT_LIMIT, swpr_pkg::RST_HIGH_WAIT_LIMIT};
    pad_phase = swpr_pkg::PH_IDLE;
    pad_tick  = '0;
    pad_bits  = '0;
    pad_reply = '0;
    pad_cmd   = '0;
    pad_us    = '0;
    @(negedge clk);

    tx_idle_pct = 18;
    rx_idle_pct = 78;
    set_timing(8'd0, 8'd0, 8'd0, 8'd0);
    foreach (dir_rows[i]) begin
      it.line_in       = dir_rows[i].line;
      it.response_word = dir_rows[i].word;
      send_beat(it, dir_rows[i].typed, dir_rows[i].exp);
    end
    run_traffic(80);
    settle();

    set_timing(rand_cfg(1, 3), rand_cfg(1, 8), rand_cfg(1, 12), rand_cfg(1, 12));
    run_traffic(250);
    settle();

    tx_idle_pct = 78;
    rx_idle_pct = 18;
    set_timing(rand_cfg(0, 2), rand_cfg(0, 6), rand_cfg(0, 10), rand_cfg(0, 10));
    run_traffic(250);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_timing(8'd1, 8'd4, 8'd40, 8'd40);
    hold_go = 1'b1;
    send_frame(1'b0);
    repeat (3) line_tick(1'b1, 1'b0);
    send_frame(1'b1);
    repeat (3) line_tick(1'b1, 1'b0);
    settle();

    if (errors == 0) begin
      $display("single_wire_pad_responder_unit verification clean");
    end else begin
      $display("single_wire_pad_responder_unit verification failed");
    end
    $finish;
  end

endmodule
